FILE: rtl/dog_extremum_detector_defines.svh
// ----------------------------------------------------------------------------
// dog_extremum_detector_defines
// Assertion macros used by the extremum detector top level. Each macro expects
// clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef DOG_EXTREMUM_DETECTOR_DEFINES_SVH
`define DOG_EXTREMUM_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DOGX_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dogx assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DOGX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dogx assertion failed");

`endif

FILE: rtl/dogx_pkg.sv
// ----------------------------------------------------------------------------
// dogx_pkg
// Shared constants, register indexes and types of the extremum detector.
// ----------------------------------------------------------------------------
package dogx_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
	localparam int SAMPLE_BITS    = 16;
	localparam int DIM_BITS       = 11;
	localparam int THR_BITS       = 15;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 15;
	localparam int WIN_SIZE       = 27;
	localparam int WIN_CENTRE     = 13;
	localparam int MIN_DIM        = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH        = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT       = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET     = 11'd640;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET    = 11'd480;
	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 15'd109;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t below;
		sample_t middle;
		sample_t above;
	} triple_t;

	// Centre position of the window once this pixel is in, and whether it is judged.
	typedef struct packed {
		logic                judge;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} pos_t;

endpackage

FILE: rtl/dogx_if.sv
// ----------------------------------------------------------------------------
// dogx_if
// Valid/ready channels of the extremum detector: pixel triples in, extrema out.
// ----------------------------------------------------------------------------
interface dogx_in_if import dogx_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    frame_start;
	sample_t prev_layer_value;
	sample_t cur_layer_value;
	sample_t next_layer_value;

	modport source (output valid, frame_start, prev_layer_value, cur_layer_value,
		next_layer_value, input ready);
	modport sink (input valid, frame_start, prev_layer_value, cur_layer_value,
		next_layer_value, output ready);
endinterface

interface dogx_out_if import dogx_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [9:0]    centre_row;
	logic [9:0]    centre_col;
	sample_t       centre_value;
	logic          is_maximum;

	modport source (output valid, centre_row, centre_col, centre_value, is_maximum,
		input ready);
	modport sink (input valid, centre_row, centre_col, centre_value, is_maximum,
		output ready);
endinterface

FILE: rtl/dogx_raster.sv
// ----------------------------------------------------------------------------
// dogx_raster
// Raster position tracking: column and row counters with frame restart.
// ----------------------------------------------------------------------------
module dogx_raster import dogx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                frame_start,
	input  logic [DIM_BITS-1:0] width_cfg,
	input  logic [DIM_BITS-1:0] height_cfg,
	output logic [COL_BITS-1:0] col,
	output logic                bank,
	output pos_t                pos
);

	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [DIM_BITS-1:0] w_eff;
	logic [DIM_BITS-1:0] h_eff;
	logic [COL_BITS-1:0] col_cur;
	logic [ROW_BITS-1:0] row_cur;
	logic [DIM_BITS-1:0] col_inc;
	logic [DIM_BITS-1:0] row_inc;
	logic [COL_BITS-1:0] col_next;
	logic [ROW_BITS-1:0] row_next;

	always_comb begin
		priority if (width_cfg < DIM_BITS'(MIN_DIM)) begin
			w_eff = DIM_BITS'(MIN_DIM);
		end else if (width_cfg > DIM_BITS'(MAX_WIDTH)) begin
			w_eff = DIM_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_cfg;
		end
		priority if (height_cfg < DIM_BITS'(MIN_DIM)) begin
			h_eff = DIM_BITS'(MIN_DIM);
		end else if (height_cfg > DIM_BITS'(MAX_HEIGHT)) begin
			h_eff = DIM_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = height_cfg;
		end
	end

	// A narrowed frame can leave the counters past the new edge; they wrap then.
	always_comb begin
		if (frame_start || DIM_BITS'(col_q) >= w_eff) begin
			col_cur = '0;
		end else begin
			col_cur = col_q;
		end
		if (frame_start || DIM_BITS'(row_q) >= h_eff) begin
			row_cur = '0;
		end else begin
			row_cur = row_q;
		end
		col_inc = DIM_BITS'(col_cur) + DIM_BITS'(1);
		row_inc = DIM_BITS'(row_cur) + DIM_BITS'(1);
		if (col_inc >= w_eff) begin
			col_next = '0;
			row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
		end else begin
			col_next = col_inc[COL_BITS-1:0];
			row_next = row_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	assign col       = col_cur;
	assign bank      = row_cur[0];
	assign pos.judge = (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
	assign pos.row   = row_cur - ROW_BITS'(1);
	assign pos.col   = col_cur - COL_BITS'(1);

endmodule

FILE: rtl/dogx_line_store.sv
// ----------------------------------------------------------------------------
// dogx_line_store
// Two-row line store of one layer, one bank per row parity, read-first.
// ----------------------------------------------------------------------------
module dogx_line_store import dogx_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [COL_BITS-1:0] col,
	input  logic                bank,
	input  sample_t             wdata,
	output sample_t             top,
	output sample_t             mid
);

	sample_t even_mem [MAX_WIDTH];
	sample_t odd_mem  [MAX_WIDTH];
	sample_t even_rd_q;
	sample_t odd_rd_q;
	logic    bank_q;

	// The bank of the current row parity holds row r-2 and takes row r.
	always_ff @(posedge clk) begin
		if (en) begin
			even_rd_q <= even_mem[col];
			if (!bank) begin
				even_mem[col] <= wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			odd_rd_q <= odd_mem[col];
			if (bank) begin
				odd_mem[col] <= wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bank_q <= bank;
		end
	end

	assign top = bank_q ? odd_rd_q : even_rd_q;
	assign mid = bank_q ? even_rd_q : odd_rd_q;

endmodule

FILE: rtl/dogx_window.sv
// ----------------------------------------------------------------------------
// dogx_window
// 3x3x3 neighbour window and the per-neighbour comparisons against its centre.
// ----------------------------------------------------------------------------
module dogx_window import dogx_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  triple_t             top,
	input  triple_t             mid,
	input  triple_t             fresh,
	output sample_t             centre,
	output logic [WIN_SIZE-1:0] le_flags,
	output logic [WIN_SIZE-1:0] ge_flags
);

	sample_t win_q [WIN_SIZE];
	sample_t col_in [3][3];

	// Entry order is layer*9 + row*3 + column; column 2 is the newest.
	always_comb begin
		col_in[0][0] = top.below;
		col_in[0][1] = mid.below;
		col_in[0][2] = fresh.below;
		col_in[1][0] = top.middle;
		col_in[1][1] = mid.middle;
		col_in[1][2] = fresh.middle;
		col_in[2][0] = top.above;
		col_in[2][1] = mid.above;
		col_in[2][2] = fresh.above;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_SIZE; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			for (int l = 0; l < 3; l++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[l*9 + r*3]     <= win_q[l*9 + r*3 + 1];
					win_q[l*9 + r*3 + 1] <= win_q[l*9 + r*3 + 2];
					win_q[l*9 + r*3 + 2] <= col_in[l][r];
				end
			end
		end
	end

	assign centre = win_q[WIN_CENTRE];

	always_comb begin
		for (int i = 0; i < WIN_SIZE; i++) begin
			le_flags[i] = (win_q[i] <= centre);
			ge_flags[i] = (win_q[i] >= centre);
		end
	end

endmodule

FILE: rtl/dog_extremum_detector.sv
// ----------------------------------------------------------------------------
// dog_extremum_detector
// 3x3x3 scale-space extremum detector on a difference-of-Gaussian stream.
// ----------------------------------------------------------------------------
// Usage: the samples channel carries one co-located triple per pixel (layer
// below, middle layer, layer above) in raster order; frame_start marks row 0,
// column 0. When pixel (r,c) with r>=2 and c>=2 arrives, pixel (r-1,c-1) is
// judged, and the extrema channel carries its row, column, value and
// polarity if its magnitude exceeds the threshold and no neighbour in the
// 3x3x3 cube is beyond it (ties pass).
// Throughput is one pixel per cycle unless the receiver stalls: each layer's
// line store is a pair of single-port banks, read and written once per
// transfer at the same column. A result passes line store read, window
// shift, compare and reduce, each registered, before it leaves the output
// register.
// Reset clears the raster counters, the window and all valid flags and loads
// the register defaults; line store contents stay undefined until written.
// When the receiver stalls, pixels keep being taken until the pipeline ahead
// of the output register is full; pixels that produce no result never hold
// up the stream. Registers are written through wr_en, wr_index and wr_data;
// the user must write only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
`include "dog_extremum_detector_defines.svh"

module dog_extremum_detector import dogx_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	dogx_in_if.sink                   samples,
	dogx_out_if.source                extrema
);

	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [THR_BITS-1:0] thr_q;

	logic en1, en2, en3, en_out;
	logic accept;
	logic v1_s1, v2_s2, v3_s3;

	logic [COL_BITS-1:0] wr_col;
	logic                wr_bank;
	pos_t                pos;
	triple_t             fresh;
	triple_t             top;
	triple_t             mid;

	pos_t                pos_s1;
	triple_t             fresh_s1;
	pos_t                pos_s2;
	pos_t                pos_s3;
	sample_t             centre;
	logic [WIN_SIZE-1:0] le_flags;
	logic [WIN_SIZE-1:0] ge_flags;
	sample_t             centre_s3;
	logic [WIN_SIZE-1:0] le_s3;
	logic [WIN_SIZE-1:0] ge_s3;
	logic                mag_ok_s3;

	logic [SAMPLE_BITS:0] centre_ext;
	logic [SAMPLE_BITS:0] mag;
	logic                 mag_ok;
	logic                 hit;

	logic                res_valid_q;
	logic [ROW_BITS-1:0] res_row_q;
	logic [COL_BITS-1:0] res_col_q;
	sample_t             res_value_q;
	logic                res_max_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:        width_q  <= wr_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT:       height_q <= wr_data[DIM_BITS-1:0];
				REG_CONTRAST_THRESHOLD: thr_q    <= wr_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Each stage moves when it is empty or the stage after it moves.
	assign en_out        = !res_valid_q || extrema.ready;
	assign en3           = !v3_s3 || en_out;
	assign en2           = !v2_s2 || en3;
	assign en1           = !v1_s1 || en2;
	assign samples.ready = en1;
	assign accept        = samples.valid && en1;

	assign fresh.below  = samples.prev_layer_value;
	assign fresh.middle = samples.cur_layer_value;
	assign fresh.above  = samples.next_layer_value;

	dogx_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.frame_start (samples.frame_start),
		.width_cfg   (width_q),
		.height_cfg  (height_q),
		.col         (wr_col),
		.bank        (wr_bank),
		.pos         (pos)
	);

	dogx_line_store u_store_below (
		.clk   (clk),
		.en    (accept),
		.col   (wr_col),
		.bank  (wr_bank),
		.wdata (fresh.below),
		.top   (top.below),
		.mid   (mid.below)
	);

	dogx_line_store u_store_middle (
		.clk   (clk),
		.en    (accept),
		.col   (wr_col),
		.bank  (wr_bank),
		.wdata (fresh.middle),
		.top   (top.middle),
		.mid   (mid.middle)
	);

	dogx_line_store u_store_above (
		.clk   (clk),
		.en    (accept),
		.col   (wr_col),
		.bank  (wr_bank),
		.wdata (fresh.above),
		.top   (top.above),
		.mid   (mid.above)
	);

	// Stage 1: line store read in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1   <= pos;
			fresh_s1 <= samples.valid ? fresh : fresh_s1;
		end
	end

	// Stage 2: the window shifts in the new column as the item enters.
	dogx_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (en2 && v1_s1),
		.top      (top),
		.mid      (mid),
		.fresh    (fresh_s1),
		.centre   (centre),
		.le_flags (le_flags),
		.ge_flags (ge_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pos_s2 <= pos_s1;
		end
	end

	// Stage 3: comparisons registered.
	assign centre_ext = {centre[SAMPLE_BITS-1], centre};
	assign mag        = centre[SAMPLE_BITS-1] ? (~centre_ext + 1'b1) : centre_ext;
	assign mag_ok     = mag > {{(SAMPLE_BITS+1-THR_BITS){1'b0}}, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			pos_s3    <= pos_s2;
			centre_s3 <= centre;
			le_s3     <= le_flags;
			ge_s3     <= ge_flags;
			mag_ok_s3 <= mag_ok;
		end
	end

	// A zero centre never passes the magnitude test, so the sign bit picks the side.
	assign hit = v3_s3 && pos_s3.judge && mag_ok_s3 &&
		(centre_s3[SAMPLE_BITS-1] ? (&ge_s3) : (&le_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && hit) begin
			res_row_q   <= pos_s3.row;
			res_col_q   <= pos_s3.col;
			res_value_q <= centre_s3;
			res_max_q   <= !centre_s3[SAMPLE_BITS-1];
		end
	end

	assign extrema.valid        = res_valid_q;
	assign extrema.centre_row   = res_row_q;
	assign extrema.centre_col   = res_col_q;
	assign extrema.centre_value = res_value_q;
	assign extrema.is_maximum   = res_max_q;

	`DOGX_ASSERT_SAME(a_polarity, res_valid_q, res_max_q == !res_value_q[SAMPLE_BITS-1])
	`DOGX_ASSERT_SAME(a_nonzero, res_valid_q, res_value_q != '0)
	`DOGX_ASSERT_SAME(a_interior, res_valid_q, res_row_q != '0 && res_col_q != '0)
	`DOGX_ASSERT_NEXT(a_frame_origin, accept && samples.frame_start, v1_s1 && !pos_s1.judge)

endmodule
